// ----- src/lrwk_pkg.sv -----
// Package for the two-link leg polar kinematics pipeline.
// Holds fixed-point widths, CORDIC constants and the arctangent table.
`default_nettype none
package lrwk_pkg;
   localparam int NumLegs  = 4;
   localparam int LinkW    = 15;
   localparam int AngW     = 16;
   localparam int CordW    = 34;
   localparam int AtanLen  = 24;
   localparam int CsrIdxW  = 2;

   localparam logic signed [CordW-1:0] Q30Pi     = 34'sd3373259426;
   localparam logic signed [CordW-1:0] Q30HalfPi = 34'sd1686629713;
   localparam logic signed [CordW-1:0] CordGain  = 34'sd652032874;
   localparam logic [LinkW-1:0]        LinkReset = 15'd8192;

   function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return CordW'(signed'({2'b00, v}));
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767)       return 16'sh7FFF;
      else if (v < -64'sd32768) return 16'sh8000;
      else                      return v[15:0];
   endfunction
endpackage
`default_nettype wire

// ----- src/leg_rotating_workspace_kinematics.sv -----
// Top level: polar kinematics, velocity and torque mapping of a two-link leg.
// Uses lrwk_pkg, lrwk_cordic and lrwk_divider.
// One item enters per clock while advance is high. Each item passes the input register,
// CORDIC chain, three Jacobian and product stages, divider setup stage, 17-stage quotient
// chain and output register. The whole pipeline advances together whenever the output
// register is empty or being taken, so a stalled result holds every stage.
`default_nettype none
module leg_rotating_workspace_kinematics #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write,
   input  wire logic [1:0]          csr_index,
   input  wire logic [14:0]         csr_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_leg_index,
   input  wire logic signed [15:0]  req_hip_angle,
   input  wire logic signed [15:0]  req_knee_angle,
   input  wire logic signed [15:0]  req_hip_rate,
   input  wire logic signed [15:0]  req_knee_rate,
   input  wire logic signed [15:0]  req_force_radial,
   input  wire logic signed [15:0]  req_force_angular,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [15:0]              rsp_radial_length,
   output logic signed [15:0]       rsp_polar_angle,
   output logic signed [15:0]       rsp_radial_rate,
   output logic signed [15:0]       rsp_polar_rate,
   output logic signed [15:0]       rsp_hip_torque,
   output logic signed [15:0]       rsp_knee_torque,
   output logic                     rsp_rate_saturated
);
   import lrwk_pkg::*;

   logic [LinkW-1:0] link_ff [NumLegs];
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumLegs; i++) link_ff[i] <= LinkReset;
      end else if (csr_write) begin
         link_ff[csr_index] <= csr_data;
      end
   end

   // stage A: capture, angle reduction
   localparam int SideW = LinkW + 1 + 4 * 16;
   logic                    a_v_ff;
   logic signed [CordW-1:0] a_z_ff;
   logic [SideW-1:0]        a_side_ff;
   logic signed [CordW-1:0] z_raw;
   logic signed [CordW-1:0] z_red;
   logic                    neg;

   always_comb begin
      z_raw = CordW'(req_knee_angle) <<< 17;
      neg   = 1'b0;
      z_red = z_raw;
      if (z_raw > Q30HalfPi) begin
         z_red = z_raw - Q30Pi;
         neg   = 1'b1;
      end else if (z_raw < -Q30HalfPi) begin
         z_red = z_raw + Q30Pi;
         neg   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (advance) begin
         a_v_ff <= req_valid;
      end
      if (advance) begin
         a_z_ff    <= z_red;
         a_side_ff <= {link_ff[req_leg_index], neg, req_hip_angle, req_knee_angle,
                       req_hip_rate, req_knee_rate};
      end
   end

   // forces are carried separately to keep side bus compact
   logic signed [15:0] fr_a_ff, fa_a_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         fr_a_ff <= req_force_radial;
         fa_a_ff <= req_force_angular;
      end
   end

   logic                    c_v;
   logic signed [CordW-1:0] c_x, c_y;
   logic [SideW-1:0]        c_side;
   logic [31:0]             c_f;

   lrwk_cordic #(.Stages(CORDIC_STAGES), .SideW(SideW + 32)) u_cordic (
      .clock, .reset, .advance,
      .in_valid (a_v_ff),
      .in_z     (a_z_ff),
      .in_side  ({a_side_ff, fr_a_ff, fa_a_ff}),
      .out_valid(c_v),
      .out_x    (c_x),
      .out_y    (c_y),
      .out_side ({c_side, c_f})
   );

   logic [LinkW-1:0]   c_len;
   logic               c_neg;
   logic signed [15:0] c_h, c_k, c_wh, c_wk, c_fr, c_fa;
   assign {c_len, c_neg, c_h, c_k, c_wh, c_wk} = c_side;
   assign {c_fr, c_fa} = c_f;

   // stage B: L*s and L*c
   logic               b_v_ff;
   logic signed [50:0] b_ls_ff, b_lc_ff;
   logic signed [15:0] b_h_ff, b_k_ff, b_wh_ff, b_wk_ff, b_fr_ff, b_fa_ff;
   logic signed [CordW-1:0] sn, cs;
   assign sn = c_neg ? -c_y : c_y;
   assign cs = c_neg ? -c_x : c_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (advance) begin
         b_v_ff <= c_v;
      end
      if (advance) begin
         b_ls_ff <= 51'(sn) * signed'({1'b0, c_len});
         b_lc_ff <= 51'(cs) * signed'({1'b0, c_len});
         b_h_ff <= c_h; b_k_ff <= c_k; b_wh_ff <= c_wh; b_wk_ff <= c_wk;
         b_fr_ff <= c_fr; b_fa_ff <= c_fa;
      end
   end

   // stage C: Jacobian, radius, polar angle
   logic               cc_v_ff;
   logic signed [36:0] js_ff, jc_ff;
   logic [15:0]        r_ff;
   logic signed [15:0] pa_ff;
   logic signed [15:0] cc_wh_ff, cc_wk_ff, cc_fr_ff, cc_fa_ff;
   logic signed [50:0] r_raw;
   logic signed [17:0] pa_sum;

   always_comb begin
      r_raw  = (b_lc_ff + 51'sd268435456) >>> 29;
      pa_sum = (18'(b_h_ff) * 18'sd2 + 18'(b_k_ff) + 18'sd1) >>> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_v_ff <= 1'b0;
      end else if (advance) begin
         cc_v_ff <= b_v_ff;
      end
      if (advance) begin
         js_ff <= 37'((b_ls_ff + 51'sd16384) >>> 15);
         jc_ff <= 37'((b_lc_ff + 51'sd16384) >>> 15);
         if (r_raw < 0)                 r_ff <= '0;
         else if (r_raw > 51'sd65535)   r_ff <= 16'hFFFF;
         else                           r_ff <= r_raw[15:0];
         pa_ff <= sat16(64'(pa_sum));
         cc_wh_ff <= b_wh_ff; cc_wk_ff <= b_wk_ff;
         cc_fr_ff <= b_fr_ff; cc_fa_ff <= b_fa_ff;
      end
   end

   // stage D: products
   logic               d_v_ff;
   logic signed [55:0] vr_p_ff, num_ff, jf_ff, sf_ff;
   logic [15:0]        d_r_ff;
   logic signed [15:0] d_pa_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (advance) begin
         d_v_ff <= cc_v_ff;
      end
      if (advance) begin
         vr_p_ff <= 56'(js_ff) * -56'(cc_wk_ff);
         num_ff  <= 56'(jc_ff) * (56'(cc_wh_ff) * 56'sd2 + 56'(cc_wk_ff));
         jf_ff   <= 56'(jc_ff) * 56'(cc_fa_ff);
         sf_ff   <= 56'(js_ff) * 56'(cc_fr_ff);
         d_r_ff  <= r_ff;
         d_pa_ff <= pa_ff;
      end
   end

   // stage E: roundings, divider setup
   localparam int EW = 16 * 5 + 2;
   logic               e_v_ff;
   logic [63:0]        e_mag_ff;
   logic [15:0]        e_den_ff;
   logic [EW-1:0]      e_side_ff;
   logic signed [15:0] vr_s, ht_s, kt_s, pr_z;
   logic               num_neg, zero_r;
   always_comb begin
      num_neg = num_ff < 0;
      zero_r  = d_r_ff == '0;
      vr_s = sat16(64'((vr_p_ff + 56'sd536870912) >>> 30));
      ht_s = sat16(64'((jf_ff * 56'sd2 + 56'sd536870912) >>> 30));
      kt_s = sat16(64'((jf_ff - sf_ff + 56'sd536870912) >>> 30));
      if (num_ff > 0)      pr_z = 16'sh7FFF;
      else if (num_neg)    pr_z = 16'sh8000;
      else                 pr_z = '0;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (advance) begin
         e_v_ff <= d_v_ff;
      end
      if (advance) begin
         e_mag_ff  <= 64'(num_neg ? -num_ff : num_ff) + ({48'd0, d_r_ff} << 14);
         e_den_ff  <= d_r_ff;
         e_side_ff <= {num_neg, zero_r, 16'(d_r_ff), d_pa_ff, vr_s, ht_s, kt_s};
      end
   end
   logic signed [15:0] pz_e_ff;
   always_ff @(posedge clock) begin
      if (advance) pz_e_ff <= pr_z;
   end

   logic               q_v;
   logic [16:0]        q_quo;
   logic [EW+15:0]     q_side;
   lrwk_divider #(.SideW(EW + 16)) u_div (
      .clock, .reset, .advance,
      .in_valid (e_v_ff),
      .in_num   (e_mag_ff),
      .in_den   (e_den_ff),
      .in_side  ({e_side_ff, pz_e_ff}),
      .out_valid(q_v),
      .out_quo  (q_quo),
      .out_side (q_side)
   );

   logic               f_neg, f_zero;
   logic [15:0]        f_r;
   logic signed [15:0] f_pa, f_vr, f_ht, f_kt, f_pz;
   assign {f_neg, f_zero, f_r, f_pa, f_vr, f_ht, f_kt, f_pz} = q_side;

   logic signed [15:0] pr_o;
   logic               sat_o;
   always_comb begin
      sat_o = 1'b0;
      if (f_zero) begin
         pr_o  = f_pz;
         sat_o = 1'b1;
      end else if (f_neg) begin
         if (q_quo > 17'd32768) begin
            pr_o = 16'sh8000; sat_o = 1'b1;
         end else begin
            pr_o = -signed'(q_quo[15:0]);
         end
      end else begin
         if (q_quo > 17'd32767) begin
            pr_o = 16'sh7FFF; sat_o = 1'b1;
         end else begin
            pr_o = signed'(q_quo[15:0]);
         end
      end
   end

   logic               o_v_ff, o_sat_ff;
   logic [15:0]        o_r_ff;
   logic signed [15:0] o_pa_ff, o_vr_ff, o_pr_ff, o_ht_ff, o_kt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (advance) begin
         o_v_ff <= q_v;
      end
      if (advance) begin
         o_r_ff <= f_r; o_pa_ff <= f_pa; o_vr_ff <= f_vr; o_pr_ff <= pr_o;
         o_ht_ff <= f_ht; o_kt_ff <= f_kt; o_sat_ff <= sat_o;
      end
   end

   assign rsp_valid          = o_v_ff;
   assign rsp_radial_length  = o_r_ff;
   assign rsp_polar_angle    = o_pa_ff;
   assign rsp_radial_rate    = o_vr_ff;
   assign rsp_polar_rate     = o_pr_ff;
   assign rsp_hip_torque     = o_ht_ff;
   assign rsp_knee_torque    = o_kt_ff;
   assign rsp_rate_saturated = o_sat_ff;
endmodule
`default_nettype wire

// ----- src/lrwk_cordic.sv -----
// Pipelined rotation-mode CORDIC stage chain with stall support.
// Depends on lrwk_pkg for widths and the arctangent table.
`default_nettype none
module lrwk_cordic #(
   parameter int Stages = 16,
   parameter int SideW  = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           in_valid,
   input  wire logic signed [lrwk_pkg::CordW-1:0] in_z,
   input  wire logic [SideW-1:0]               in_side,
   output logic                                out_valid,
   output logic signed [lrwk_pkg::CordW-1:0]   out_x,
   output logic signed [lrwk_pkg::CordW-1:0]   out_y,
   output logic [SideW-1:0]                    out_side
);
   import lrwk_pkg::*;
   localparam int Run = (Stages < AtanLen) ? Stages : AtanLen;

   logic                    v_ff [Run+1];
   logic signed [CordW-1:0] x_ff [Run+1];
   logic signed [CordW-1:0] y_ff [Run+1];
   logic signed [CordW-1:0] z_ff [Run+1];
   logic [SideW-1:0]        s_ff [Run+1];

   always_comb begin
      v_ff[0] = in_valid;
      x_ff[0] = CordGain;
      y_ff[0] = '0;
      z_ff[0] = in_z;
      s_ff[0] = in_side;
   end

   for (genvar i = 0; i < Run; i++) begin : g_stage
      logic signed [CordW-1:0] x_in, y_in, z_in;
      always_comb begin
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - atan_q30(5'(i));
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + atan_q30(5'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (advance) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (advance) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
            s_ff[i+1] <= s_ff[i];
         end
      end
   end

   assign out_valid = v_ff[Run];
   assign out_x     = x_ff[Run];
   assign out_y     = y_ff[Run];
   assign out_side  = s_ff[Run];
endmodule
`default_nettype wire

// ----- src/lrwk_divider.sv -----
// Pipelined restoring divider: 17-bit quotient of a magnitude by r<<15.
// Depends on lrwk_pkg; one quotient bit per stage.
`default_nettype none
module lrwk_divider #(
   parameter int SideW = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire logic [63:0]       in_num,
   input  wire logic [15:0]       in_den,
   input  wire logic [SideW-1:0]  in_side,
   output logic                   out_valid,
   output logic [16:0]            out_quo,
   output logic [SideW-1:0]       out_side
);
   import lrwk_pkg::*;
   localparam int QW = 17;

   logic              v_ff [QW+1];
   logic [63:0]       n_ff [QW+1];
   logic [15:0]       d_ff [QW+1];
   logic [QW-1:0]     q_ff [QW+1];
   logic [SideW-1:0]  s_ff [QW+1];

   always_comb begin
      v_ff[0] = in_valid;
      n_ff[0] = in_num;
      d_ff[0] = in_den;
      q_ff[0] = '0;
      s_ff[0] = in_side;
   end

   for (genvar i = 0; i < QW; i++) begin : g_bit
      localparam int Sh = 15 + QW - 1 - i;
      logic [63:0] trial;
      logic        take;
      always_comb begin
         trial = 64'(d_ff[i]) << Sh;
         take  = n_ff[i] >= trial;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (advance) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (advance) begin
            n_ff[i+1] <= take ? n_ff[i] - trial : n_ff[i];
            d_ff[i+1] <= d_ff[i];
            q_ff[i+1] <= {q_ff[i][QW-2:0], take};
            s_ff[i+1] <= s_ff[i];
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_quo   = q_ff[QW];
   assign out_side  = s_ff[QW];
endmodule
`default_nettype wire

// ----- src/lrwk_checker.sv -----
// Port-level checker for the leg kinematics top level, with its bind.
// Sees only the top level's ports.
`default_nettype none
module lrwk_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_polar_rate,
   input wire logic        rsp_rate_saturated,
   input wire logic [15:0] rsp_radial_length
);
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready) else $error("ready while stalled");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_polar_rate)) else $error("result moved");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_radial_length == 16'd0) |-> rsp_rate_saturated)
      else $error("zero radius without flag");
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("valid after reset");
endmodule

bind leg_rotating_workspace_kinematics lrwk_checker u_lrwk_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready, .rsp_polar_rate,
   .rsp_rate_saturated, .rsp_radial_length
);
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for leg_rotating_workspace_kinematics: random and directed leg samples.
// Predicts each result with a local fixed-point CORDIC model; depends on lrwk_pkg and the RTL.
module testbench;
   import lrwk_pkg::*;

   typedef struct packed {
      logic [1:0] leg;
      logic signed [15:0] hip, knee, hip_w, knee_w, f_rad, f_ang;
   } sample_type;

   typedef struct packed {
      logic [15:0] radius;
      logic signed [15:0] polar, v_rad, v_pol, t_hip, t_knee;
      logic sat;
   } foot_type;

   localparam int Stages = 16;
   localparam int Latency = Stages + 22;
   localparam int WatchLimit = 20000;

   logic clock = 0, reset = 1;
   logic csr_write = 0;
   logic [1:0] csr_index = '0;
   logic [14:0] csr_data = '0;
   logic req_valid = 0, req_ready;
   logic [1:0] req_leg_index = '0;
   logic signed [15:0] req_hip_angle = '0, req_knee_angle = '0, req_hip_rate = '0;
   logic signed [15:0] req_knee_rate = '0, req_force_radial = '0, req_force_angular = '0;
   logic rsp_valid, rsp_ready = 0;
   logic [15:0] rsp_radial_length;
   logic signed [15:0] rsp_polar_angle, rsp_radial_rate, rsp_polar_rate;
   logic signed [15:0] rsp_hip_torque, rsp_knee_torque;
   logic rsp_rate_saturated;

   leg_rotating_workspace_kinematics #(.CORDIC_STAGES(Stages)) u_top (.*);

   initial forever #4 clock = ~clock;

   longint link_len [NumLegs];
   sample_type pending_samples[$];
   foot_type expected_feet[$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0, gap_left = 0;
   bit hold_sender = 0;
   bit long_stall = 0;
   int stall_left = 0;

   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint rnd_shr(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic foot_type foot_of(sample_type s);
      foot_type f;
      longint len, z, x, y, nx, ny, sn, cs, js, jc, r, num, q, d, mag;
      longint at[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
         64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
         64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
         64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
         64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
      bit flip;
      len = link_len[s.leg];
      z = longint'(s.knee) * 131072;
      x = 64'sd652032874; y = 0; flip = 0;
      if (z > 64'sd1686629713) begin z -= 64'sd3373259426; flip = 1; end
      else if (z < -64'sd1686629713) begin z += 64'sd3373259426; flip = 1; end
      for (int i = 0; i < Stages && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - shr(y, i); ny = y + shr(x, i); z -= at[i];
         end else begin
            nx = x + shr(y, i); ny = y - shr(x, i); z += at[i];
         end
         x = nx; y = ny;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
      js = rnd_shr(len * sn, 15);
      jc = rnd_shr(len * cs, 15);
      r = rnd_shr(len * cs, 29);
      if (r < 0) r = 0;
      if (r > 65535) r = 65535;
      f.radius = r[15:0];
      f.polar = 16'(clip16(rnd_shr(2 * longint'(s.hip) + s.knee, 1)));
      f.v_rad = 16'(clip16(rnd_shr(js * (-longint'(s.knee_w)), 30)));
      num = jc * (2 * longint'(s.hip_w) + s.knee_w);
      f.sat = 0;
      if (r == 0) begin
         f.sat = 1;
         f.v_pol = num > 0 ? 16'sh7FFF : (num < 0 ? 16'sh8000 : 16'sh0);
      end else begin
         d = r <<< 15;
         mag = num < 0 ? -num : num;
         q = (mag + (d >>> 1)) / d;
         if (q > 40000) q = 40000;
         q = num < 0 ? -q : q;
         if (q > 32767 || q < -32768) f.sat = 1;
         f.v_pol = 16'(clip16(q));
      end
      f.t_hip = 16'(clip16(rnd_shr(2 * jc * s.f_ang, 30)));
      f.t_knee = 16'(clip16(rnd_shr(jc * s.f_ang - js * s.f_rad, 30)));
      return f;
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      s.leg = 2'($urandom_range(0, 3));
      s.hip = 16'($urandom); s.knee = 16'($urandom);
      s.hip_w = 16'($urandom); s.knee_w = 16'($urandom);
      s.f_rad = 16'($urandom); s.f_ang = 16'($urandom);
      case ($urandom_range(0, 5))
         0: s.knee = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1: begin
            s.hip_w = 16'($urandom_range(0, 60) - 30);
            s.knee_w = 16'($urandom_range(0, 60) - 30);
         end
         2: s.knee = 16'($urandom_range(0, 25000) - 12500);
         default: ;
      endcase
      return s;
   endfunction

   // driver
   always @(posedge clock) begin
      if (req_valid && req_ready) begin
         expected_feet.push_back(foot_of(pending_samples.pop_front()));
      end
      if (!reset && !hold_sender && (!req_valid || req_ready)) begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         end
         if (burst_left > 0 && pending_samples.size() > 0) begin
            burst_left--;
            req_valid <= 1;
            req_leg_index <= pending_samples[0].leg;
            req_hip_angle <= pending_samples[0].hip;
            req_knee_angle <= pending_samples[0].knee;
            req_hip_rate <= pending_samples[0].hip_w;
            req_knee_rate <= pending_samples[0].knee_w;
            req_force_radial <= pending_samples[0].f_rad;
            req_force_angular <= pending_samples[0].f_ang;
         end else begin
            if (gap_left > 0) gap_left--;
            req_valid <= 0;
         end
      end else if (hold_sender && req_valid && req_ready) begin
         req_valid <= 0;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (long_stall && stall_left == 0) stall_left = 300;
      if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) long_stall = 0;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 7) > 1) || ($urandom_range(0, 99) < 20);
      end
   end

   // monitor
   always @(posedge clock) begin
      foot_type e, a;
      if (rsp_valid && rsp_ready) begin
         a = '{rsp_radial_length, rsp_polar_angle, rsp_radial_rate, rsp_polar_rate,
               rsp_hip_torque, rsp_knee_torque, rsp_rate_saturated};
         if (expected_feet.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transfer %p", a);
         end else begin
            e = expected_feet.pop_front();
            if (a !== e) begin
               errors++;
               if (errors <= 10) $display("mismatch exp %p got %p", e, a);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("FAIL leg_rotating_workspace_kinematics");
         $finish;
      end
   end

   task automatic drain();
      while (pending_samples.size() > 0 || req_valid || expected_feet.size() > 0)
         @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   task automatic write_link(int idx, int val);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= 2'(idx);
      csr_data <= 15'(val);
      @(posedge clock);
      csr_write <= 0;
      link_len[idx] = val & 16'h7FFF;
   endtask

   initial begin
      sample_type s;
      int lens[5] = '{8192, 1, 32767, 0, 4321};
      foreach (link_len[i]) link_len[i] = 8192;
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed samples at reset lengths
      for (int i = 0; i < 20; i++) begin
         s = random_sample();
         s.leg = 2'(i % 4);
         case (i)
            0: s = '0;
            1: s = '{2'd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
            2: s = '{2'd2, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
            3: s.knee = 16'sd12868;
            4: s.knee = -16'sd12868;
            5: begin s.knee = 16'sd12867; s.hip_w = 16'sh7FFF; s.knee_w = 16'sh7FFF; end
            6: begin s.knee = 16'sd0; s.hip_w = 16'sh0; s.knee_w = 16'sh0; end
            default: ;
         endcase
         pending_samples.push_back(s);
      end
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         for (int l = 0; l < 4; l++)
            write_link(l, phase < 5 ? lens[(phase + l) % 5] : $urandom_range(1, 32767));
         if (phase == 1) long_stall = 1;
         for (int i = 0; i < 305; i++) pending_samples.push_back(random_sample());
         if (phase == 3) begin
            while (pending_samples.size() > 150) @(posedge clock);
            hold_sender = 1;
            while (req_valid || expected_feet.size() > 0) @(posedge clock);
            hold_sender = 0;
         end
         drain();
      end
      if (errors == 0) begin
         $display("PASS leg_rotating_workspace_kinematics");
      end else begin
         $display("FAIL leg_rotating_workspace_kinematics");
      end
      $finish;
   end

   initial begin
      csr_write = 0;
   end
endmodule
